// ===== hw/rtl/elb_pkg.sv =====
`default_nettype none
package elb_pkg;

  typedef enum logic [1:0] {
    ACT_LOG   = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_UPD,
    S_DRN_RD,
    S_DRN_EMIT,
    S_RESP
  } state_t;

  localparam logic REG_OVERRUN = 1'b0;
  localparam logic [7:0] OVERRUN_RESET = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  event_code;
    logic [31:0] event_value;
    logic [31:0] timestamp;
    logic [5:0]  max_read;
  } elb_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  out_code;
    logic [31:0] out_value;
    logic [31:0] out_time;
    logic [5:0]  fill_level;
    logic [7:0]  kind_count;
    logic        last_of_run;
  } elb_out_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] value;
    logic [31:0] stamp;
  } rec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/elb_record_store.sv =====
`default_nettype none
module elb_record_store #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire elb_pkg::rec_t  wdata,
  input  wire logic           re,
  input  wire logic [AW-1:0]  raddr,
  output elb_pkg::rec_t       rdata
);
  import elb_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/elb_kind_bank.sv =====
`default_nettype none
module elb_kind_bank #(
  parameter int KINDS = 32,
  parameter int CB = 8,
  parameter int KAW = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           re,
  input  wire logic [KAW-1:0] raddr,
  output logic [CB-1:0]       rdata,
  input  wire logic           we,
  input  wire logic [KAW-1:0] waddr,
  input  wire logic [CB-1:0]  wdata
);
  import elb_pkg::*;

  logic [CB-1:0] mem [KINDS];
  logic [KINDS-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= written[raddr] ? mem[raddr] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/event_log_buffer.sv =====
`default_nettype none
// Event log with per-kind saturating counters. Requests enter on req_* and results
// leave on rsp_* through one output register. A log or query request steps through
// accept, counter read, and counter update with record write and result load; a
// drain is set up at accept and then reads and emits each record in turn, paced by the
// registered read of the single record memory and the shared slot adder that steps the
// read pointer. An empty drain or an unused action goes from accept to a response state.
// A result waits while the output register is full and stalled. The block takes no new
// request until the current one has loaded its last result. Counters read as zero
// until first written, so no clearing pass follows reset. overrun_code is written
// over the APB port at byte address 0 and resets to 255.
module event_log_buffer #(
  parameter int STORE_DEPTH = 32,
  parameter int NUM_EVENT_KINDS = 32,
  parameter int COUNT_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire elb_pkg::elb_in_t  req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output elb_pkg::elb_out_t      rsp_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import elb_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int HW = $clog2(STORE_DEPTH + 1);
  localparam int SW = HW + 1;
  localparam int KAW = (NUM_EVENT_KINDS > 1) ? $clog2(NUM_EVENT_KINDS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state, state_next;
  elb_in_t item;
  logic [AW-1:0] oldest;
  logic [AW-1:0] rd_ptr;
  logic [HW-1:0] held;
  logic [HW-1:0] remaining;
  logic [7:0] overrun_code;

  logic accept;
  logic out_free;
  logic full;
  logic in_range;
  logic [HW-1:0] drain_n;
  logic [31:0] mr_ext;
  logic [31:0] held_ext;

  logic [AW-1:0] add_a;
  logic [HW-1:0] add_b;
  logic [SW-1:0] add_sum;
  logic [SW-1:0] add_wrap;
  logic [AW-1:0] slot;

  logic cnt_re;
  logic cnt_we;
  logic [KAW-1:0] cnt_addr;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [31:0] cnt_rd_ext;
  logic [31:0] cnt_new_ext;

  logic rec_we;
  logic rec_re;
  rec_t rec_wdata;
  rec_t rec_rdata;

  logic load_out;
  elb_out_t out_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OVERRUN) ? {24'd0, overrun_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      overrun_code <= OVERRUN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_OVERRUN) begin
      overrun_code <= pwdata[7:0];
    end
  end

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && (state == S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;
  assign full = (held == HW'(STORE_DEPTH));
  assign in_range = (32'(item.event_code) < NUM_EVENT_KINDS);

  assign mr_ext = 32'(req_data.max_read);
  assign held_ext = 32'(held);
  assign drain_n = HW'((mr_ext < held_ext) ? mr_ext : held_ext);

  // shared slot adder with wrap
  always_comb begin
    case (state)
      S_CNT_UPD: begin
        add_a = oldest;
        add_b = full ? HW'(STORE_DEPTH - 1) : held;
      end
      S_DRN_EMIT: begin
        add_a = rd_ptr;
        add_b = HW'(1);
      end
      default: begin
        add_a = oldest;
        add_b = drain_n;
      end
    endcase
  end

  assign add_sum = SW'(add_a) + SW'(add_b);
  assign add_wrap = (add_sum >= SW'(STORE_DEPTH)) ? add_sum - SW'(STORE_DEPTH) : add_sum;
  assign slot = AW'(add_wrap);

  assign cnt_new = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
  assign cnt_rd_ext = 32'(cnt_rd);
  assign cnt_new_ext = 32'(cnt_new);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_data.action)
            ACT_LOG, ACT_QUERY: state_next = S_CNT_RD;
            ACT_DRAIN: state_next = (drain_n == '0) ? S_RESP : S_DRN_RD;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_CNT_RD: state_next = S_CNT_UPD;
      S_CNT_UPD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DRN_RD: state_next = S_DRN_EMIT;
      S_DRN_EMIT: begin
        if (out_free) begin
          state_next = (remaining == HW'(1)) ? S_IDLE : S_DRN_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_re = 1'b0;
    cnt_we = 1'b0;
    cnt_addr = KAW'(item.event_code);
    rec_we = 1'b0;
    rec_re = 1'b0;
    rec_wdata.code = item.event_code;
    rec_wdata.value = item.event_value;
    rec_wdata.stamp = item.timestamp;
    load_out = 1'b0;
    out_next = '0;
    out_next.fill_level = 6'(held);
    out_next.last_of_run = 1'b1;
    if (full) begin
      rec_wdata.code = overrun_code;
      rec_wdata.value = 32'(item.event_code);
    end
    case (state)
      S_CNT_RD: cnt_re = 1'b1;
      S_CNT_UPD: begin
        load_out = out_free;
        if (item.action == ACT_LOG) begin
          rec_we = out_free;
          cnt_we = out_free && in_range;
          out_next.fill_level = full ? 6'(held) : 6'(held + HW'(1));
          out_next.kind_count = in_range ? cnt_new_ext[7:0] : 8'd0;
        end else begin
          out_next.kind_count = in_range ? cnt_rd_ext[7:0] : 8'd0;
        end
      end
      S_DRN_RD: rec_re = 1'b1;
      S_DRN_EMIT: begin
        load_out = out_free;
        out_next.valid_res = 1'b1;
        out_next.out_code = rec_rdata.code;
        out_next.out_value = rec_rdata.value;
        out_next.out_time = rec_rdata.stamp;
        out_next.last_of_run = (remaining == HW'(1));
      end
      S_RESP: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oldest <= '0;
      held <= '0;
      rd_ptr <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (accept && req_data.action == ACT_DRAIN) begin
        held <= held - drain_n;
        oldest <= slot;
        rd_ptr <= oldest;
        remaining <= drain_n;
      end
      if (rec_we && !full) begin
        held <= held + HW'(1);
      end
      if (state == S_DRN_EMIT && out_free) begin
        rd_ptr <= slot;
        remaining <= remaining - HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_data <= out_next;
    end
  end

  elb_record_store #(
    .DEPTH(STORE_DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(rec_we),
    .waddr(slot),
    .wdata(rec_wdata),
    .re(rec_re),
    .raddr(rd_ptr),
    .rdata(rec_rdata)
  );

  elb_kind_bank #(
    .KINDS(NUM_EVENT_KINDS),
    .CB(COUNT_BITS),
    .KAW(KAW)
  ) u_kinds (
    .clk(clk),
    .rst(rst),
    .re(cnt_re),
    .raddr(cnt_addr),
    .rdata(cnt_rd),
    .we(cnt_we),
    .waddr(cnt_addr),
    .wdata(cnt_new)
  );

endmodule
`default_nettype wire

// ===== dv/tb_event_log_buffer.sv =====
module tb_event_log_buffer;
  import elb_pkg::*;

  localparam int DEPTH = 32;
  localparam int KINDS = 32;
  localparam int AW = $clog2(DEPTH);
  localparam int KW = $clog2(KINDS);
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 26;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  elb_in_t     req_data;
  logic        rsp_valid;
  logic        rsp_stall;
  elb_out_t    rsp_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  event_log_buffer u_dut (.*);

  logic [7:0]  log_code  [DEPTH];
  logic [31:0] log_value [DEPTH];
  logic [31:0] log_stamp [DEPTH];
  logic [7:0]  kind_tally [KINDS];
  logic [7:0]  overrun_now;
  int          head_slot;
  int          held_count;
  elb_out_t    pending_results[$];
  elb_out_t    want_result;

  int mismatch_count;
  int requests_sent;
  int results_seen;
  int overrun_hits;
  int code_settings;
  int burst_left;
  int hold_off_left;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void predict_request(input elb_in_t req);
    elb_out_t      res;
    logic [AW-1:0] slot;
    logic [KW-1:0] kind;
    int            n;
    res = '0;
    res.last_of_run = 1'b1;
    kind = KW'(req.event_code);
    case (action_t'(req.action))
      ACT_LOG: begin
        if (held_count < DEPTH) begin
          slot = AW'((head_slot + held_count) % DEPTH);
          log_code[slot] = req.event_code;
          log_value[slot] = req.event_value;
          held_count++;
        end else begin
          slot = AW'((head_slot + DEPTH - 1) % DEPTH);
          log_code[slot] = overrun_now;
          log_value[slot] = {24'h0, req.event_code};
          overrun_hits++;
        end
        log_stamp[slot] = req.timestamp;
        if (int'(req.event_code) < KINDS) begin
          if (kind_tally[kind] != 8'hFF)
            kind_tally[kind] = kind_tally[kind] + 8'd1;
          res.kind_count = kind_tally[kind];
        end
        res.fill_level = 6'(held_count);
        pending_results.push_back(res);
      end
      ACT_DRAIN: begin
        n = (int'(req.max_read) < held_count) ? int'(req.max_read) : held_count;
        if (n == 0) begin
          res.fill_level = 6'(held_count);
          pending_results.push_back(res);
        end else begin
          held_count -= n;
          for (int i = 0; i < n; i++) begin
            slot = AW'((head_slot + i) % DEPTH);
            res.valid_res = 1'b1;
            res.out_code = log_code[slot];
            res.out_value = log_value[slot];
            res.out_time = log_stamp[slot];
            res.fill_level = 6'(held_count);
            res.last_of_run = (i == n - 1);
            pending_results.push_back(res);
          end
          head_slot = (head_slot + n) % DEPTH;
        end
      end
      ACT_QUERY: begin
        if (int'(req.event_code) < KINDS)
          res.kind_count = kind_tally[kind];
        res.fill_level = 6'(held_count);
        pending_results.push_back(res);
      end
      default: begin
        res.fill_level = 6'(held_count);
        pending_results.push_back(res);
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual %p", $time, rsp_data);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("valid_res", 32'(want_result.valid_res), 32'(rsp_data.valid_res));
        check_field("out_code", 32'(want_result.out_code), 32'(rsp_data.out_code));
        check_field("out_value", want_result.out_value, rsp_data.out_value);
        check_field("out_time", want_result.out_time, rsp_data.out_time);
        check_field("fill_level", 32'(want_result.fill_level), 32'(rsp_data.fill_level));
        check_field("kind_count", 32'(want_result.kind_count), 32'(rsp_data.kind_count));
        check_field("last_of_run", 32'(want_result.last_of_run),
                    32'(rsp_data.last_of_run));
      end
    end
  end

  initial begin : rsp_stall_gen
    int window_left;
    int stall_pct;
    window_left = 0;
    stall_pct = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(8, 64);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        window_left--;
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic elb_in_t make_request(input action_t act, input logic [7:0] code,
                                           input logic [31:0] value, input logic [31:0] stamp,
                                           input logic [5:0] max_read);
    elb_in_t req;
    req.action = act;
    req.event_code = code;
    req.event_value = value;
    req.timestamp = stamp;
    req.max_read = max_read;
    return req;
  endfunction

  function automatic elb_in_t random_request(input int log_pct);
    elb_in_t req;
    int      pick;
    req.event_value = $urandom;
    req.timestamp = $urandom;
    if ($urandom_range(0, 4) == 0)
      req.event_code = 8'($urandom);
    else
      req.event_code = 8'($urandom_range(0, KINDS - 1));
    req.max_read = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < log_pct) begin
      req.action = ACT_LOG;
    end else if (pick < log_pct + (100 - log_pct) * 6 / 10) begin
      req.action = ACT_DRAIN;
      case ($urandom_range(0, 5))
        0: req.max_read = 6'($urandom_range(0, 63));
        1: req.max_read = 6'($urandom_range(0, DEPTH));
        default: req.max_read = 6'($urandom_range(1, 8));
      endcase
    end else if (pick < 97) begin
      req.action = ACT_QUERY;
    end else begin
      req.action = ACT_RSVD;
    end
    return req;
  endfunction

  task automatic send_request(input elb_in_t req);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!no_gaps)
        gap = $urandom_range(0, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      req_data <= random_request(50);
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= req;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request(req);
    requests_sent++;
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_overrun_code(input logic [7:0] code);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_OVERRUN, 2'b00};
    pwdata <= {24'h0, code};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    overrun_now = code;
    code_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== code) begin
      $display("%0t: overrun_code readback expected %0h actual %0h", $time, code, prdata[7:0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(make_request(ACT_QUERY, 8'd0, '0, '0, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd31, '0, '0, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd5));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd0));
    send_request(make_request(ACT_RSVD, 8'hFF, '1, '1, 6'h3F));
  endtask

  task automatic test_field_extremes();
    send_request(make_request(ACT_LOG, 8'd0, 32'h0, 32'h0, 6'd0));
    send_request(make_request(ACT_LOG, 8'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F));
    send_request(make_request(ACT_LOG, 8'd32, 32'h0000_1234, 32'h5, 6'd1));
    send_request(make_request(ACT_LOG, 8'd255, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd32, '0, '0, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd255, '0, '0, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd31, '0, '0, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd0, '0, '0, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd1));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'h3F));
    send_request(make_request(ACT_LOG, 8'd1, 32'h8000_0001, 32'h7FFF_FFFE, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd32));
  endtask

  task automatic test_log_overrun();
    wait_for_idle();
    write_overrun_code(8'h00);
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'h3F));
    for (int i = 0; i < DEPTH; i++)
      send_request(make_request(ACT_LOG, 8'($urandom_range(0, KINDS - 1)), $urandom,
                                $urandom, 6'd0));
    send_request(make_request(ACT_LOG, 8'd3, $urandom, $urandom, 6'd0));
    send_request(make_request(ACT_LOG, 8'd200, $urandom, $urandom, 6'd0));
    send_request(make_request(ACT_LOG, 8'd17, $urandom, $urandom, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd32));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd5));
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 260; i++) begin
      if (i % 40 == 39)
        send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd32));
      send_request(make_request(ACT_LOG, 8'd9, $urandom, $urandom, 6'd0));
    end
    send_request(make_request(ACT_QUERY, 8'd9, '0, '0, 6'd0));
    send_request(make_request(ACT_LOG, 8'd9, $urandom, $urandom, 6'd0));
    send_request(make_request(ACT_QUERY, 8'd10, '0, '0, 6'd0));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd32));
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_off_left = 200;
    for (int i = 0; i < 12; i++)
      send_request(random_request(60));
    send_request(make_request(ACT_DRAIN, 8'd0, '0, '0, 6'd32));
    no_gaps = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [7:0] phase_code;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_idle();
      if (p == 0)
        phase_code = 8'h00;
      else if (p == 1)
        phase_code = 8'hFF;
      else
        phase_code = 8'($urandom);
      write_overrun_code(phase_code);
      no_gaps = (p % 2 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_request(random_request((p % 2 == 1) ? 75 : 50));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int saturated_kinds;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    overrun_now = OVERRUN_RESET;
    foreach (kind_tally[k]) kind_tally[k] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_log_overrun();
    test_count_saturation();
    test_backpressure();
    test_random_phases();

    wait_for_idle();
    repeat (16) @(posedge clk);

    saturated_kinds = 0;
    foreach (kind_tally[k])
      if (kind_tally[k] == 8'hFF) saturated_kinds++;
    $display("%0d requests in, %0d results checked, %0d logs into a full store",
             requests_sent, results_seen, overrun_hits);
    $display("%0d kinds hit the counter ceiling, overrun code written %0d times",
             saturated_kinds, code_settings);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
